// ===== hdl/csb_pkg.sv =====
// Shared types and constants for the C source balance checker.
// No dependencies; used by csb_core, c_syntax_balance_checker, csb_verdict_checker and the testbench.
`timescale 1ns / 1ps

package csb_pkg;

    localparam int OUT_LINE_BITS = 20;
    localparam logic [OUT_LINE_BITS-1:0] OUT_LINE_MAX = '1;

    typedef enum logic [2:0] {
        LM_CODE  = 3'd0,
        LM_SLASH = 3'd1,
        LM_LINE  = 3'd2,
        LM_BLOCK = 3'd3,
        LM_STAR  = 3'd4
    } lexer_mode_t;

    typedef enum logic [1:0] {
        QM_NONE   = 2'd0,
        QM_SINGLE = 2'd1,
        QM_DOUBLE = 2'd2
    } quote_mode_t;

    typedef enum logic [3:0] {
        ST_CLEAN         = 4'd0,
        ST_BAD_ESCAPE    = 4'd1,
        ST_OPEN_SINGLE   = 4'd2,
        ST_OPEN_DOUBLE   = 4'd3,
        ST_OPEN_BRACKET  = 4'd4,
        ST_EXTRA_BRACKET = 4'd5,
        ST_OPEN_PAREN    = 4'd6,
        ST_EXTRA_PAREN   = 4'd7,
        ST_OPEN_BRACE    = 4'd8,
        ST_EXTRA_BRACE   = 4'd9,
        ST_OPEN_COMMENT  = 4'd10,
        ST_OVERFLOW      = 4'd11
    } check_status_t;

    localparam logic [7:0] CH_LPAREN    = 8'h28;
    localparam logic [7:0] CH_RPAREN    = 8'h29;
    localparam logic [7:0] CH_LBRACKET  = 8'h5B;
    localparam logic [7:0] CH_RBRACKET  = 8'h5D;
    localparam logic [7:0] CH_LBRACE    = 8'h7B;
    localparam logic [7:0] CH_RBRACE    = 8'h7D;
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_SQUOTE    = 8'h27;
    localparam logic [7:0] CH_STAR      = 8'h2A;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_T         = 8'h74;
    localparam logic [7:0] CH_N         = 8'h6E;
    localparam logic [7:0] CH_B         = 8'h62;
    localparam logic [7:0] CH_ZERO      = 8'h30;

    // One byte handed from the input register to the core.
    typedef struct packed {
        logic       en;
        logic       last;
        logic [7:0] text_byte;
    } step_t;

    // Verdict produced on the final byte.
    typedef struct packed {
        check_status_t            check_status;
        logic [OUT_LINE_BITS-1:0] line_number;
    } result_t;

endpackage

// ===== hdl/c_syntax_balance_checker.sv =====
// Top level of the C source balance checker: input register, core, result register.
// Depends on csb_pkg and csb_core.
`timescale 1ns / 1ps

// C source balance checker.
//
// Slave stream: one source byte per transfer on s_axis_tdata, with
// s_axis_tlast marking the final byte of a text. Master stream: one verdict
// per text, sent only after the final byte, carrying the status code and a
// line number (the line of the first error, or the last line when clean).
//
// Throughput: one byte per cycle, sustained while no final byte is held (see
// Stalls). Each byte updates the lexer mode, quote and escape flags, the three
// depth counters and the line counter at once; that update loop sets the rate.
// The final byte is first held in the input register; its verdict is then
// loaded into the result register, which drives m_axis_tvalid.
//
// Stalls: while a verdict waits on m_axis_tready, ordinary bytes keep
// flowing; only a further final byte is held in the input register, which
// in turn drops s_axis_tready until the pending verdict is taken.
//
// Reset (rst_n low, asynchronous) empties both registers and returns the
// checker to line 1, no nesting, code mode, no error. The checker also
// returns to that state by itself after every final byte.
module c_syntax_balance_checker #(
    parameter int DEPTH_BITS = 8,
    parameter int LINE_BITS  = 20
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
    input  logic        s_axis_tlast,   // end_of_text
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // [3:0] check_status, [23:4] line_number
);

    logic             in_valid_reg, in_valid_next;
    logic             in_last_reg, in_last_next;
    logic [7:0]       in_byte_reg, in_byte_next;
    logic             out_valid_reg, out_valid_next;
    csb_pkg::result_t out_data_reg, out_data_next;

    logic             advance;
    logic             in_take;
    csb_pkg::step_t   step;
    csb_pkg::result_t result;

    // a held byte moves on unless it is a final byte and the result slot is busy
    assign advance = in_valid_reg &&
                     (!in_last_reg || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    assign step.en        = advance;
    assign step.last      = in_last_reg;
    assign step.text_byte = in_byte_reg;

    csb_core #(
        .DEPTH_BITS (DEPTH_BITS),
        .LINE_BITS  (LINE_BITS)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .result (result)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        in_last_next  = in_last_reg;
        in_byte_next  = in_byte_reg;
        if (in_take)
        begin
            in_valid_next = 1'b1;
            in_last_next  = s_axis_tlast;
            in_byte_next  = s_axis_tdata;
        end
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (advance && in_last_reg)
        begin
            out_valid_next = 1'b1;
            out_data_next  = result;
        end
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        in_last_reg  <= in_last_next;
        in_byte_reg  <= in_byte_next;
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_data_reg.line_number, out_data_reg.check_status};

    // a final byte that cannot move on keeps its place and its contents
    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_byte_reg) &&
                                     $stable(in_last_reg))
        else $error("held input byte lost or altered");

    // a pending verdict is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_axis_tready |-> !(advance && in_last_reg))
        else $error("verdict overwritten while stalled");

    // only a final byte can stall the input side
    a_stall_last_only: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |-> in_last_reg && out_valid_reg)
        else $error("ordinary byte stalled");

endmodule

// ===== hdl/csb_core.sv =====
// Lexer state, nesting counters and error latch of the balance checker.
// Depends on csb_pkg.
`timescale 1ns / 1ps

module csb_core #(
    parameter int DEPTH_BITS = 8,
    parameter int LINE_BITS  = 20
) (
    input  logic            clk,
    input  logic            rst_n,
    input  csb_pkg::step_t  step,
    output csb_pkg::result_t result
);

    localparam int LW = (LINE_BITS > csb_pkg::OUT_LINE_BITS) ? LINE_BITS
                                                            : csb_pkg::OUT_LINE_BITS;

    logic [LINE_BITS-1:0]  line_count_reg, line_count_next;
    logic [DEPTH_BITS-1:0] paren_reg, paren_next;
    logic [DEPTH_BITS-1:0] bracket_reg, bracket_next;
    logic [DEPTH_BITS-1:0] brace_reg, brace_next;
    csb_pkg::lexer_mode_t  mode_reg, mode_next;
    csb_pkg::quote_mode_t  quote_reg, quote_next;
    logic                  escape_reg, escape_next;
    csb_pkg::check_status_t err_reg, err_next;
    logic [LINE_BITS-1:0]  err_line_reg, err_line_next;

    // post-byte values, before the end-of-text clear
    logic [LINE_BITS-1:0]  line_upd;
    logic [DEPTH_BITS-1:0] paren_upd, bracket_upd, brace_upd;
    csb_pkg::lexer_mode_t  mode_upd;
    csb_pkg::quote_mode_t  quote_upd;
    logic                  escape_upd;
    csb_pkg::check_status_t err_upd;
    logic [LINE_BITS-1:0]  err_line_upd;

    logic [7:0]            c;
    logic                  do_code;
    logic                  count_nl;
    logic                  raise;
    csb_pkg::check_status_t raise_code;
    logic [LINE_BITS-1:0]  res_line;
    logic [LW-1:0]         res_line_ext;

    assign c = step.text_byte;

    // lexer: decides whether the byte is code, and handles comment modes
    always_comb
    begin
        mode_upd = mode_reg;
        do_code  = 1'b0;
        count_nl = 1'b0;
        unique case (mode_reg)
            csb_pkg::LM_LINE:
            begin
                if (c == csb_pkg::CH_NEWLINE)
                begin
                    count_nl = 1'b1;
                    mode_upd = csb_pkg::LM_CODE;
                end
            end
            csb_pkg::LM_BLOCK:
            begin
                if (c == csb_pkg::CH_NEWLINE)
                    count_nl = 1'b1;
                if (c == csb_pkg::CH_STAR)
                    mode_upd = csb_pkg::LM_STAR;
            end
            csb_pkg::LM_STAR:
            begin
                if (c == csb_pkg::CH_SLASH)
                    mode_upd = csb_pkg::LM_CODE;
                else if (c != csb_pkg::CH_STAR)
                begin
                    count_nl = (c == csb_pkg::CH_NEWLINE);
                    mode_upd = csb_pkg::LM_BLOCK;
                end
            end
            csb_pkg::LM_SLASH:
            begin
                if (c == csb_pkg::CH_STAR)
                    mode_upd = csb_pkg::LM_BLOCK;
                else if (c == csb_pkg::CH_SLASH)
                    mode_upd = csb_pkg::LM_LINE;
                else
                begin
                    mode_upd = csb_pkg::LM_CODE;
                    do_code  = 1'b1;
                end
            end
            default:
            begin
                mode_upd = csb_pkg::LM_CODE;
                do_code  = 1'b1;
            end
        endcase

        // code byte: escapes, quotes, brackets
        quote_upd   = quote_reg;
        escape_upd  = escape_reg;
        paren_upd   = paren_reg;
        bracket_upd = bracket_reg;
        brace_upd   = brace_reg;
        raise       = 1'b0;
        raise_code  = csb_pkg::ST_CLEAN;
        if (do_code)
        begin
            if (escape_reg)
            begin
                escape_upd = 1'b0;
                if (c != csb_pkg::CH_BACKSLASH && c != csb_pkg::CH_T &&
                    c != csb_pkg::CH_SQUOTE && c != csb_pkg::CH_DQUOTE &&
                    c != csb_pkg::CH_N && c != csb_pkg::CH_B && c != csb_pkg::CH_ZERO)
                begin
                    raise      = 1'b1;
                    raise_code = csb_pkg::ST_BAD_ESCAPE;
                end
            end
            else if (c == csb_pkg::CH_BACKSLASH)
                escape_upd = 1'b1;
            else if (c == csb_pkg::CH_NEWLINE)
            begin
                if (quote_reg == csb_pkg::QM_SINGLE)
                begin
                    raise      = 1'b1;
                    raise_code = csb_pkg::ST_OPEN_SINGLE;
                end
                else if (quote_reg == csb_pkg::QM_DOUBLE)
                begin
                    raise      = 1'b1;
                    raise_code = csb_pkg::ST_OPEN_DOUBLE;
                end
                else
                    count_nl = 1'b1;
            end
            else if (quote_reg == csb_pkg::QM_DOUBLE)
            begin
                if (c == csb_pkg::CH_DQUOTE)
                    quote_upd = csb_pkg::QM_NONE;
            end
            else if (quote_reg == csb_pkg::QM_SINGLE)
            begin
                if (c == csb_pkg::CH_SQUOTE)
                    quote_upd = csb_pkg::QM_NONE;
            end
            else
            begin
                quote_upd = csb_pkg::QM_NONE;
                case (c)
                    csb_pkg::CH_DQUOTE: quote_upd = csb_pkg::QM_DOUBLE;
                    csb_pkg::CH_SQUOTE: quote_upd = csb_pkg::QM_SINGLE;
                    csb_pkg::CH_SLASH:  mode_upd  = csb_pkg::LM_SLASH;
                    csb_pkg::CH_LPAREN:
                    begin
                        if (&paren_reg)
                        begin
                            raise      = 1'b1;
                            raise_code = csb_pkg::ST_OVERFLOW;
                        end
                        else
                            paren_upd = paren_reg + 1'b1;
                    end
                    csb_pkg::CH_RPAREN:
                    begin
                        if (paren_reg == '0)
                        begin
                            raise      = 1'b1;
                            raise_code = csb_pkg::ST_EXTRA_PAREN;
                        end
                        else
                            paren_upd = paren_reg - 1'b1;
                    end
                    csb_pkg::CH_LBRACKET:
                    begin
                        if (&bracket_reg)
                        begin
                            raise      = 1'b1;
                            raise_code = csb_pkg::ST_OVERFLOW;
                        end
                        else
                            bracket_upd = bracket_reg + 1'b1;
                    end
                    csb_pkg::CH_RBRACKET:
                    begin
                        if (bracket_reg == '0)
                        begin
                            raise      = 1'b1;
                            raise_code = csb_pkg::ST_EXTRA_BRACKET;
                        end
                        else
                            bracket_upd = bracket_reg - 1'b1;
                    end
                    csb_pkg::CH_LBRACE:
                    begin
                        if (&brace_reg)
                        begin
                            raise      = 1'b1;
                            raise_code = csb_pkg::ST_OVERFLOW;
                        end
                        else
                            brace_upd = brace_reg + 1'b1;
                    end
                    csb_pkg::CH_RBRACE:
                    begin
                        if (brace_reg == '0)
                        begin
                            raise      = 1'b1;
                            raise_code = csb_pkg::ST_EXTRA_BRACE;
                        end
                        else
                            brace_upd = brace_reg - 1'b1;
                    end
                    default: ;
                endcase
            end
        end

        // line counter saturates; an error never coincides with a newline count
        line_upd = line_count_reg;
        if (count_nl && !(&line_count_reg))
            line_upd = line_count_reg + 1'b1;

        err_upd      = err_reg;
        err_line_upd = err_line_reg;
        if (raise)
        begin
            err_upd      = raise_code;
            err_line_upd = line_count_reg;
        end

        // once an error is latched, bytes are ignored
        if (err_reg != csb_pkg::ST_CLEAN)
        begin
            line_upd     = line_count_reg;
            paren_upd    = paren_reg;
            bracket_upd  = bracket_reg;
            brace_upd    = brace_reg;
            mode_upd     = mode_reg;
            quote_upd    = quote_reg;
            escape_upd   = escape_reg;
            err_upd      = err_reg;
            err_line_upd = err_line_reg;
        end
    end

    // verdict and next state
    always_comb
    begin
        result.check_status = csb_pkg::ST_CLEAN;
        if (err_upd != csb_pkg::ST_CLEAN)
            result.check_status = err_upd;
        else if (escape_upd)
            result.check_status = csb_pkg::ST_BAD_ESCAPE;
        else if (quote_upd == csb_pkg::QM_SINGLE)
            result.check_status = csb_pkg::ST_OPEN_SINGLE;
        else if (quote_upd == csb_pkg::QM_DOUBLE)
            result.check_status = csb_pkg::ST_OPEN_DOUBLE;
        else if (bracket_upd != '0)
            result.check_status = csb_pkg::ST_OPEN_BRACKET;
        else if (paren_upd != '0)
            result.check_status = csb_pkg::ST_OPEN_PAREN;
        else if (brace_upd != '0)
            result.check_status = csb_pkg::ST_OPEN_BRACE;
        else if (mode_upd == csb_pkg::LM_BLOCK || mode_upd == csb_pkg::LM_STAR)
            result.check_status = csb_pkg::ST_OPEN_COMMENT;

        res_line     = (err_upd != csb_pkg::ST_CLEAN) ? err_line_upd : line_upd;
        res_line_ext = LW'(res_line);
        if (res_line_ext > LW'(csb_pkg::OUT_LINE_MAX))
            result.line_number = csb_pkg::OUT_LINE_MAX;
        else
            result.line_number = res_line_ext[csb_pkg::OUT_LINE_BITS-1:0];

        line_count_next = line_count_reg;
        paren_next      = paren_reg;
        bracket_next    = bracket_reg;
        brace_next      = brace_reg;
        mode_next       = mode_reg;
        quote_next      = quote_reg;
        escape_next     = escape_reg;
        err_next        = err_reg;
        err_line_next   = err_line_reg;
        if (step.en)
        begin
            if (step.last)
            begin
                line_count_next = LINE_BITS'(1);
                paren_next      = '0;
                bracket_next    = '0;
                brace_next      = '0;
                mode_next       = csb_pkg::LM_CODE;
                quote_next      = csb_pkg::QM_NONE;
                escape_next     = 1'b0;
                err_next        = csb_pkg::ST_CLEAN;
                err_line_next   = '0;
            end
            else
            begin
                line_count_next = line_upd;
                paren_next      = paren_upd;
                bracket_next    = bracket_upd;
                brace_next      = brace_upd;
                mode_next       = mode_upd;
                quote_next      = quote_upd;
                escape_next     = escape_upd;
                err_next        = err_upd;
                err_line_next   = err_line_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_count_reg <= LINE_BITS'(1);
            paren_reg      <= '0;
            bracket_reg    <= '0;
            brace_reg      <= '0;
            mode_reg       <= csb_pkg::LM_CODE;
            quote_reg      <= csb_pkg::QM_NONE;
            escape_reg     <= 1'b0;
            err_reg        <= csb_pkg::ST_CLEAN;
            err_line_reg   <= '0;
        end
        else
        begin
            line_count_reg <= line_count_next;
            paren_reg      <= paren_next;
            bracket_reg    <= bracket_next;
            brace_reg      <= brace_next;
            mode_reg       <= mode_next;
            quote_reg      <= quote_next;
            escape_reg     <= escape_next;
            err_reg        <= err_next;
            err_line_reg   <= err_line_next;
        end
    end

    // final byte returns everything to its reset values
    a_clear_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        step.en && step.last |=> line_count_reg == LINE_BITS'(1) &&
                                 err_reg == csb_pkg::ST_CLEAN && paren_reg == '0)
        else $error("state not cleared after final byte");

    // a latched error and its line hold until the final byte
    a_error_holds: assert property (@(posedge clk) disable iff (!rst_n)
        err_reg != csb_pkg::ST_CLEAN && !(step.en && step.last)
        |=> $stable(err_reg) && $stable(err_line_reg))
        else $error("latched error changed before end of text");

    // an error is always tagged with a real line
    a_error_line: assert property (@(posedge clk) disable iff (!rst_n)
        err_reg != csb_pkg::ST_CLEAN |-> err_line_reg != '0)
        else $error("error latched with line zero");

    a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        line_count_reg != '0)
        else $error("line counter reached zero");

endmodule

// ===== verif/csb_verdict_checker.sv =====
// Scoreboard for the C source balance checker: predicts each verdict from the
// byte stream and compares it with the master stream. Depends on csb_pkg.
`timescale 1ns / 1ps

module csb_verdict_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
    input  logic        s_axis_tlast,   // end_of_text
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [23:0] m_axis_tdata,   // [3:0] check_status, [23:4] line_number
    output int          mismatches,
    output int          pending,
    output int          verdicts,
    output logic [11:0] statuses_hit
);

    // predicted lexer state
    csb_pkg::lexer_mode_t              lex;
    csb_pkg::quote_mode_t              quo;
    logic                              esc;
    csb_pkg::check_status_t            err;
    logic [csb_pkg::OUT_LINE_BITS-1:0] err_line;
    logic [csb_pkg::OUT_LINE_BITS-1:0] line_cnt;
    logic [7:0]                        paren_lvl;
    logic [7:0]                        bracket_lvl;
    logic [7:0]                        brace_lvl;

    csb_pkg::result_t verdict_q[$];
    int               miss_cnt;
    int               verd_cnt;

    task automatic clear_state();
        lex         = csb_pkg::LM_CODE;
        quo         = csb_pkg::QM_NONE;
        esc         = 1'b0;
        err         = csb_pkg::ST_CLEAN;
        err_line    = '0;
        line_cnt    = csb_pkg::OUT_LINE_BITS'(1);
        paren_lvl   = '0;
        bracket_lvl = '0;
        brace_lvl   = '0;
    endtask

    task automatic note_error(input csb_pkg::check_status_t code);
        if (err == csb_pkg::ST_CLEAN)
        begin
            err      = code;
            err_line = line_cnt;
        end
    endtask

    task automatic bump_line();
        if (line_cnt != '1)
            line_cnt = line_cnt + 1'b1;
    endtask

    task automatic open_level(inout logic [7:0] lvl);
        if (lvl == '1)
            note_error(csb_pkg::ST_OVERFLOW);
        else
            lvl = lvl + 1'b1;
    endtask

    task automatic close_level(inout logic [7:0] lvl, input csb_pkg::check_status_t code);
        if (lvl == '0)
            note_error(code);
        else
            lvl = lvl - 1'b1;
    endtask

    // byte seen as code (or inside a quote)
    task automatic code_char(input logic [7:0] c);
        if (esc)
        begin
            esc = 1'b0;
            if (c != csb_pkg::CH_BACKSLASH && c != csb_pkg::CH_T &&
                c != csb_pkg::CH_SQUOTE && c != csb_pkg::CH_DQUOTE &&
                c != csb_pkg::CH_N && c != csb_pkg::CH_B && c != csb_pkg::CH_ZERO)
                note_error(csb_pkg::ST_BAD_ESCAPE);
        end
        else if (c == csb_pkg::CH_BACKSLASH)
            esc = 1'b1;
        else if (c == csb_pkg::CH_NEWLINE)
        begin
            if (quo == csb_pkg::QM_SINGLE)
                note_error(csb_pkg::ST_OPEN_SINGLE);
            else if (quo == csb_pkg::QM_DOUBLE)
                note_error(csb_pkg::ST_OPEN_DOUBLE);
            else
                bump_line();
        end
        else if (quo == csb_pkg::QM_DOUBLE)
        begin
            if (c == csb_pkg::CH_DQUOTE)
                quo = csb_pkg::QM_NONE;
        end
        else if (quo == csb_pkg::QM_SINGLE)
        begin
            if (c == csb_pkg::CH_SQUOTE)
                quo = csb_pkg::QM_NONE;
        end
        else
        begin
            quo = csb_pkg::QM_NONE;
            case (c)
                csb_pkg::CH_DQUOTE:   quo = csb_pkg::QM_DOUBLE;
                csb_pkg::CH_SQUOTE:   quo = csb_pkg::QM_SINGLE;
                csb_pkg::CH_SLASH:    lex = csb_pkg::LM_SLASH;
                csb_pkg::CH_LPAREN:   open_level(paren_lvl);
                csb_pkg::CH_RPAREN:   close_level(paren_lvl, csb_pkg::ST_EXTRA_PAREN);
                csb_pkg::CH_LBRACKET: open_level(bracket_lvl);
                csb_pkg::CH_RBRACKET: close_level(bracket_lvl, csb_pkg::ST_EXTRA_BRACKET);
                csb_pkg::CH_LBRACE:   open_level(brace_lvl);
                csb_pkg::CH_RBRACE:   close_level(brace_lvl, csb_pkg::ST_EXTRA_BRACE);
                default:              ;
            endcase
        end
    endtask

    task automatic lex_char(input logic [7:0] c);
        case (lex)
            csb_pkg::LM_LINE:
            begin
                if (c == csb_pkg::CH_NEWLINE)
                begin
                    bump_line();
                    lex = csb_pkg::LM_CODE;
                end
            end
            csb_pkg::LM_BLOCK:
            begin
                if (c == csb_pkg::CH_NEWLINE)
                    bump_line();
                if (c == csb_pkg::CH_STAR)
                    lex = csb_pkg::LM_STAR;
            end
            csb_pkg::LM_STAR:
            begin
                if (c == csb_pkg::CH_SLASH)
                    lex = csb_pkg::LM_CODE;
                else if (c != csb_pkg::CH_STAR)
                begin
                    if (c == csb_pkg::CH_NEWLINE)
                        bump_line();
                    lex = csb_pkg::LM_BLOCK;
                end
            end
            csb_pkg::LM_SLASH:
            begin
                if (c == csb_pkg::CH_STAR)
                    lex = csb_pkg::LM_BLOCK;
                else if (c == csb_pkg::CH_SLASH)
                    lex = csb_pkg::LM_LINE;
                else
                begin
                    lex = csb_pkg::LM_CODE;
                    code_char(c);
                end
            end
            default:
            begin
                lex = csb_pkg::LM_CODE;
                code_char(c);
            end
        endcase
    endtask

    // verdict for the text just ended; end checks in priority order
    function automatic csb_pkg::result_t text_verdict();
        csb_pkg::result_t r;
        r.line_number = line_cnt;
        if (err != csb_pkg::ST_CLEAN)
        begin
            r.check_status = err;
            r.line_number  = err_line;
        end
        else if (esc)
            r.check_status = csb_pkg::ST_BAD_ESCAPE;
        else if (quo == csb_pkg::QM_SINGLE)
            r.check_status = csb_pkg::ST_OPEN_SINGLE;
        else if (quo == csb_pkg::QM_DOUBLE)
            r.check_status = csb_pkg::ST_OPEN_DOUBLE;
        else if (bracket_lvl != '0)
            r.check_status = csb_pkg::ST_OPEN_BRACKET;
        else if (paren_lvl != '0)
            r.check_status = csb_pkg::ST_OPEN_PAREN;
        else if (brace_lvl != '0)
            r.check_status = csb_pkg::ST_OPEN_BRACE;
        else if (lex == csb_pkg::LM_BLOCK || lex == csb_pkg::LM_STAR)
            r.check_status = csb_pkg::ST_OPEN_COMMENT;
        else
            r.check_status = csb_pkg::ST_CLEAN;
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input int want, input int got);
        miss_cnt++;
        if (miss_cnt <= 10)
            $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, what, want, got);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        csb_pkg::result_t       want;
        csb_pkg::check_status_t got_st;
        logic [19:0]            got_ln;
        if (!rst_n)
        begin
            clear_state();
            verdict_q.delete();
            miss_cnt     = 0;
            verd_cnt     = 0;
            mismatches   <= 0;
            pending      <= 0;
            verdicts     <= 0;
            statuses_hit <= '0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got_st = csb_pkg::check_status_t'(m_axis_tdata[3:0]);
                got_ln = m_axis_tdata[23:4];
                verd_cnt++;
                if (verdict_q.size() == 0)
                    flag_mismatch("unexpected verdict, tdata", 0, int'(m_axis_tdata));
                else
                begin
                    want = verdict_q.pop_front();
                    if (got_st !== want.check_status)
                        flag_mismatch("check_status", int'(want.check_status),
                                      int'(got_st));
                    if (got_ln !== want.line_number)
                        flag_mismatch("line_number", int'(want.line_number),
                                      int'(got_ln));
                end
            end
            // only unlatched bytes move the lexer; the final byte resets it
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (err == csb_pkg::ST_CLEAN)
                    lex_char(s_axis_tdata);
                if (s_axis_tlast)
                begin
                    want = text_verdict();
                    verdict_q.push_back(want);
                    statuses_hit[want.check_status] <= 1'b1;
                    clear_state();
                end
            end
            mismatches <= miss_cnt;
            verdicts   <= verd_cnt;
            pending    <= verdict_q.size();
        end
    end

endmodule

// ===== verif/c_syntax_balance_checker_tb.sv =====
// Testbench top for the C source balance checker: builds C-like texts, drives
// the byte stream and reports the verdict. Depends on csb_pkg, the block and
// csb_verdict_checker.
`timescale 1ns / 1ps

module c_syntax_balance_checker_tb;

    localparam int ITEMS          = 1950;  // byte budget for the whole run
    localparam int WATCHDOG_LIMIT = 3000;  // cycles with no transfer on either side
    localparam int HOLD_CYCLES    = 400;   // long receiver hold-off

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;

    int          mismatches;
    int          pending;
    int          verdicts;
    logic [11:0] statuses_hit;

    logic        quiet;        // no idling on either side while set
    int          hold_ticket;  // bumped to ask the receiver for a hold-off
    int          idle_cycles;
    int          bytes_sent;
    int          texts_sent;

    logic [7:0]  text_q[$];    // text being assembled

    c_syntax_balance_checker u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    csb_verdict_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .mismatches    (mismatches),
        .pending       (pending),
        .verdicts      (verdicts),
        .statuses_hit  (statuses_hit)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver: random back-pressure, plus a long hold-off on request. The
    // hold-off is counted here so the sender keeps offering bytes meanwhile.
    initial
    begin
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_ticket != hold_seen)
            begin
                hold_seen = hold_ticket;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= quiet || ($urandom_range(0, 99) >= 23);
        end
    end

    // Watchdog: a run that stops moving is a failure.
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $realtime, idle_cycles);
            $display("c_syntax_balance_checker test failed");
            $finish;
        end
    end

    // One byte transfer, after a random number of idle cycles. tvalid stays
    // high afterwards so back-to-back bytes need no extra assignment.
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = 0;
        if (!quiet)
            while ($urandom_range(0, 99) < 23)
                gap++;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_text();
        for (int i = 0; i < text_q.size(); i++)
            send_byte(text_q[i], i == text_q.size() - 1);
        text_q.delete();
        texts_sent++;
    endtask

    task automatic send_str(input string s);
        for (int i = 0; i < s.len(); i++)
            text_q.push_back(s[i]);
        send_text();
    endtask

    // Stop offering and wait until every predicted verdict has been taken.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    function automatic logic [7:0] letter();
        return 8'($urandom_range(97, 122));
    endfunction

    // kind 0 paren, 1 bracket, 2 brace
    function automatic logic [7:0] bracket_char(input int kind, input bit closing);
        case (kind)
            0:       return closing ? csb_pkg::CH_RPAREN : csb_pkg::CH_LPAREN;
            1:       return closing ? csb_pkg::CH_RBRACKET : csb_pkg::CH_LBRACKET;
            default: return closing ? csb_pkg::CH_RBRACE : csb_pkg::CH_LBRACE;
        endcase
    endfunction

    function automatic logic [7:0] escape_char();
        case ($urandom_range(0, 6))
            0:       return csb_pkg::CH_BACKSLASH;
            1:       return csb_pkg::CH_T;
            2:       return csb_pkg::CH_SQUOTE;
            3:       return csb_pkg::CH_DQUOTE;
            4:       return csb_pkg::CH_N;
            5:       return csb_pkg::CH_B;
            default: return csb_pkg::CH_ZERO;
        endcase
    endfunction

    // Filler for quotes and comments: mostly things those contexts must hide.
    function automatic logic [7:0] hidden_char();
        case ($urandom_range(0, 7))
            0, 1:    return letter();
            2:       return 8'h20;
            3:       return bracket_char($urandom_range(0, 2), 1'($urandom_range(0, 1)));
            4:       return csb_pkg::CH_SQUOTE;
            5:       return csb_pkg::CH_DQUOTE;
            6:       return csb_pkg::CH_SLASH;
            default: return csb_pkg::CH_STAR;
        endcase
    endfunction

    // Mostly well-formed C-like text with random content; sometimes damaged.
    task automatic make_snippet();
        int          target;
        int          k;
        int          pos;
        logic [7:0]  c;
        logic [7:0]  closers[$];
        target = $urandom_range(3, 40);
        while (text_q.size() < target)
        begin
            case ($urandom_range(0, 11))
                0, 1: text_q.push_back(letter());
                2:    text_q.push_back($urandom_range(0, 1) ? 8'h20 : 8'($urandom_range(48, 57)));
                3:    text_q.push_back(csb_pkg::CH_NEWLINE);
                4:
                begin
                    k = $urandom_range(0, 2);
                    text_q.push_back(bracket_char(k, 1'b0));
                    closers.push_back(bracket_char(k, 1'b1));
                end
                5:
                    if (closers.size() > 0)
                        text_q.push_back(closers.pop_back());
                6:
                begin
                    text_q.push_back(csb_pkg::CH_DQUOTE);
                    repeat ($urandom_range(0, 5))
                    begin
                        if ($urandom_range(0, 3) == 0)
                        begin
                            text_q.push_back(csb_pkg::CH_BACKSLASH);
                            text_q.push_back(escape_char());
                        end
                        else
                        begin
                            do c = hidden_char(); while (c == csb_pkg::CH_DQUOTE);
                            text_q.push_back(c);
                        end
                    end
                    text_q.push_back(csb_pkg::CH_DQUOTE);
                end
                7:
                begin
                    text_q.push_back(csb_pkg::CH_SQUOTE);
                    if ($urandom_range(0, 1))
                    begin
                        text_q.push_back(csb_pkg::CH_BACKSLASH);
                        text_q.push_back(escape_char());
                    end
                    else
                    begin
                        do c = hidden_char(); while (c == csb_pkg::CH_SQUOTE);
                        text_q.push_back(c);
                    end
                    text_q.push_back(csb_pkg::CH_SQUOTE);
                end
                8:
                begin
                    text_q.push_back(csb_pkg::CH_SLASH);
                    text_q.push_back(csb_pkg::CH_SLASH);
                    repeat ($urandom_range(0, 6))
                        text_q.push_back($urandom_range(0, 5) == 0 ? csb_pkg::CH_BACKSLASH
                                                                   : hidden_char());
                    text_q.push_back(csb_pkg::CH_NEWLINE);
                end
                9:
                begin
                    // star runs and newlines inside exercise the star-seen state
                    text_q.push_back(csb_pkg::CH_SLASH);
                    text_q.push_back(csb_pkg::CH_STAR);
                    repeat ($urandom_range(0, 8))
                    begin
                        do c = ($urandom_range(0, 5) == 0) ? csb_pkg::CH_NEWLINE
                                                           : hidden_char();
                        while (c == csb_pkg::CH_SLASH);
                        text_q.push_back(c);
                    end
                    text_q.push_back(csb_pkg::CH_STAR);
                    text_q.push_back(csb_pkg::CH_SLASH);
                end
                10:
                begin
                    // division: the slash falls back to plain code
                    text_q.push_back(csb_pkg::CH_SLASH);
                    case ($urandom_range(0, 4))
                        0:       text_q.push_back(8'h20);
                        1:       text_q.push_back(letter());
                        2:       text_q.push_back(csb_pkg::CH_LPAREN);
                        3:       text_q.push_back(csb_pkg::CH_DQUOTE);
                        default: text_q.push_back(csb_pkg::CH_NEWLINE);
                    endcase
                end
                default:
                begin
                    text_q.push_back(csb_pkg::CH_BACKSLASH);
                    text_q.push_back(escape_char());
                end
            endcase
        end
        while (closers.size() > 0)
            text_q.push_back(closers.pop_back());

        if ($urandom_range(0, 99) < 35)
        begin
            pos = $urandom_range(0, text_q.size() - 1);
            case ($urandom_range(0, 4))
                0: text_q.insert(pos, 8'($urandom_range(0, 255)));
                1:
                    if (text_q.size() > 1)
                        text_q.delete(pos);
                2: text_q[pos] = 8'($urandom_range(0, 255));
                3: text_q.insert(pos, bracket_char($urandom_range(0, 2),
                                                   1'($urandom_range(0, 1))));
                default:
                begin
                    text_q.insert(pos, letter());
                    text_q.insert(pos, csb_pkg::CH_BACKSLASH);
                end
            endcase
        end
    endtask

    task automatic noise_text();
        repeat ($urandom_range(1, 20))
            text_q.push_back(8'($urandom_range(0, 255)));
    endtask

    // Nesting up to and past the depth limit, optionally closed again.
    task automatic deep_text(input int depth, input bit close_all);
        int k;
        k = $urandom_range(0, 2);
        repeat (depth)
            text_q.push_back(bracket_char(k, 1'b0));
        if (close_all)
            repeat (depth)
                text_q.push_back(bracket_char(k, 1'b1));
    endtask

    initial
    begin
        int idx;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        quiet         <= 1'b0;
        hold_ticket   <= 0;
        bytes_sent    = 0;
        texts_sent    = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: each closer with nothing open, each opener left open, open
        // quotes, a pending escape, bad escapes (one of them a newline), a
        // newline inside a quote, an open block comment, a text ending in a
        // line comment, a lone slash, and the byte extremes.
        send_str(")");
        send_str("]");
        send_str("}");
        send_str("(");
        send_str("[");
        send_str("{");
        send_str("'");
        send_str("\"");
        send_str("\\");
        send_str("\\q");
        send_str("\\\n");
        send_str("'\n");
        send_str("/*");
        send_str("//");
        send_str("/");
        send_str("()");
        text_q.push_back(8'hFF);
        send_text();
        text_q.push_back(8'h00);
        send_text();

        // Receiver holds off while short texts keep coming: the result and
        // input registers fill and the input stalls.
        hold_ticket <= hold_ticket + 1;
        repeat (12)
        begin
            repeat ($urandom_range(1, 3))
                text_q.push_back($urandom_range(0, 1) ? letter() : hidden_char());
            send_text();
        end
        drain();

        idx = 0;
        while (bytes_sent < ITEMS)
        begin
            if (idx == 14)
                quiet <= 1'b1;
            if (idx == 30)
                quiet <= 1'b0;
            if (idx == 8)
                deep_text(255, 1'b1);
            else if (idx == 24)
                deep_text(256, 1'b0);
            else if (idx == 40)
                deep_text(256, 1'b1);
            else if ($urandom_range(0, 9) == 0)
                noise_text();
            else
                make_snippet();
            send_text();
            idx++;
        end

        drain();
        repeat (8) @(posedge clk);

        $display("%0d texts, %0d bytes, %0d verdicts compared; %0d of 12 status codes seen",
                 texts_sent, bytes_sent, verdicts, $countones(statuses_hit));
        $display("covered depth-limit nesting, damaged and noisy texts, a long receiver hold-off");
        if (mismatches == 0 && pending == 0)
            $display("c_syntax_balance_checker test passed");
        else
            $display("c_syntax_balance_checker test failed");
        $finish;
    end

endmodule
